[rtl/pinhole_project_unproject_defines.svh]
// Assertion macros for the pinhole camera unit.
// Used by the top level; expects signals clk and rst in scope.
`ifndef PINHOLE_PROJECT_UNPROJECT_DEFINES_SVH
`define PINHOLE_PROJECT_UNPROJECT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PPH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pinhole unit assertion failed");

// Next-cycle implication, disabled during reset.
`define PPH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pinhole unit assertion failed");

`endif

[rtl/pph_pkg.sv]
// Package of the pinhole camera unit: constants, types and arithmetic helpers.
// No dependencies; every RTL module uses it by scoped names.
package pph_pkg;

  localparam int FRAC_BITS = 8;
  localparam int MAX_DIM   = 4096;

  localparam int CW    = 20;
  localparam int RW    = 42;
  localparam int DW    = 13;
  localparam int CFG_W = 42;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_CENTRE_X     = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTRE_Y     = 3'd1;
  localparam logic [IDX_W-1:0] REG_FOCAL_LENGTH = 3'd2;
  localparam logic [IDX_W-1:0] REG_RADIUS_SQ    = 3'd3;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

  localparam logic [CW-1:0] RST_CENTRE_X     = 20'd81920;
  localparam logic [CW-1:0] RST_CENTRE_Y     = 20'd61440;
  localparam logic [CW-1:0] RST_FOCAL_LENGTH = 20'd131072;
  localparam logic [RW-1:0] RST_RADIUS_SQ    = {RW{1'b1}};
  localparam logic [DW-1:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [DW-1:0] RST_IMAGE_HEIGHT = 13'd480;

  // Numerator magnitude, divisor and quotient widths of the divider.
  localparam int NUM_W = 52;
  localparam int DEN_W = 31;
  localparam int D_W   = NUM_W + 1;
  localparam int P_W   = NUM_W + 2;
  localparam int SQ_IN_W = 24;
  localparam int SQ_W  = 2 * SQ_IN_W;
  localparam int R2_W  = SQ_W + 1;

  localparam logic [31:0] NEG_ONE = 32'(-(1 << FRAC_BITS));

  typedef struct packed {
    logic cmd;
    logic behind;
    logic neg;
  } div_tag_t;

  typedef struct packed {
    logic [NUM_W-1:0] word;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    div_tag_t         tag;
  } div_word_t;

  typedef struct packed {
    logic [CW-1:0] centre_x;
    logic [CW-1:0] centre_y;
    logic [CW-1:0] focal_length;
    logic [RW-1:0] circle_radius_sq;
    logic [DW-1:0] image_width;
    logic [DW-1:0] image_height;
  } cam_cfg_t;

  // One restoring division step: the next numerator bit enters the remainder
  // and the quotient bit shifts into the low end of the word.
  function automatic div_word_t div_step(input div_word_t s);
    div_word_t r;
    logic [DEN_W:0] trial;
    logic ge;
    trial = {s.rem, s.word[NUM_W-1]};
    ge = (trial >= {1'b0, s.den});
    r = s;
    r.rem = ge ? DEN_W'(trial - {1'b0, s.den}) : trial[DEN_W-1:0];
    r.word = {s.word[NUM_W-2:0], ge};
    return r;
  endfunction

  function automatic logic signed [D_W-1:0] apply_sign(input logic [NUM_W-1:0] q,
                                                        input logic neg);
    logic signed [D_W-1:0] v;
    v = $signed({1'b0, q});
    return neg ? -v : v;
  endfunction

  function automatic logic signed [P_W-1:0] add_centre(input logic signed [D_W-1:0] d,
                                                        input logic [CW-1:0] c);
    logic signed [P_W-1:0] de;
    logic signed [P_W-1:0] ce;
    de = P_W'(d);
    ce = $signed(P_W'(c));
    return de + ce;
  endfunction

  // Offsets beyond 2^23 square to more than any limit, so clamp there.
  function automatic logic [SQ_IN_W-1:0] clamp_mag(input logic [NUM_W-1:0] q);
    if (q > NUM_W'(64'd8388608)) begin
      return SQ_IN_W'(24'h800000);
    end
    return q[SQ_IN_W-1:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [P_W-1:0] v);
    if (!v[P_W-1] && (|v[P_W-2:31])) begin
      return 32'h7fffffff;
    end
    if (v[P_W-1] && !(&v[P_W-2:31])) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic in_range(input logic signed [P_W-1:0] v,
                                    input logic [DW-1:0] dim);
    logic [P_W-1:0] dimc;
    logic [P_W-1:0] lim;
    dimc = P_W'(dim);
    if (dimc > P_W'(MAX_DIM)) begin
      dimc = P_W'(MAX_DIM);
    end
    lim = dimc << FRAC_BITS;
    return !v[P_W-1] && ($unsigned(v) < lim);
  endfunction

  function automatic logic radius_ok(input logic [SQ_W-1:0] sx,
                                     input logic [SQ_W-1:0] sy,
                                     input logic [RW-1:0] lim);
    logic [R2_W-1:0] r2;
    r2 = R2_W'(sx) + R2_W'(sy);
    return r2 <= R2_W'(lim);
  endfunction

endpackage

[rtl/pph_if.sv]
// Valid/ready channel interfaces of the pinhole camera unit.
// Depends on nothing; request and response beats of the top level.
interface pph_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [21:0] pixel_x;
  logic signed [21:0] pixel_y;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, command, pixel_x, pixel_y, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, command, pixel_x, pixel_y, point_x, point_y, point_z,
                output ready);
endinterface

interface pph_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic [19:0]        res_z;
  logic               pixel_valid;
  logic               behind_viewer;

  modport source (output valid, res_x, res_y, res_z, pixel_valid, behind_viewer,
                  input ready);
  modport sink (input valid, res_x, res_y, res_z, pixel_valid, behind_viewer,
                output ready);
endinterface

[rtl/pph_front.sv]
// Input stage: multiplies the point by the focal length, or forms the pixel
// offset, and loads both divider operands. Depends on pph_pkg and pph_if.
module pph_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  pph_req_if.sink             req,
  input  pph_pkg::cam_cfg_t   cfg,
  output logic                vld,
  output pph_pkg::div_word_t  wx,
  output pph_pkg::div_word_t  wy
);

  logic signed [pph_pkg::D_W-1:0] prod_x;
  logic signed [pph_pkg::D_W-1:0] prod_y;
  logic signed [22:0]             off_x;
  logic signed [22:0]             off_y;
  logic                           behind;
  pph_pkg::div_word_t             wx_next;
  pph_pkg::div_word_t             wy_next;

  assign req.ready = en;

  assign prod_x = req.point_x * $signed({1'b0, cfg.focal_length});
  assign prod_y = req.point_y * $signed({1'b0, cfg.focal_length});
  assign off_x  = 23'(req.pixel_x) - $signed({3'b0, cfg.centre_x});
  assign off_y  = 23'(req.pixel_y) - $signed({3'b0, cfg.centre_y});
  assign behind = req.command && (req.point_z[31] || (req.point_z == '0));

  // Unprojection goes through the divider as a division by one, so both
  // commands leave it in the same form.
  always_comb begin
    wx_next = '0;
    wy_next = '0;
    wx_next.tag.cmd = req.command;
    wy_next.tag.cmd = req.command;
    wx_next.tag.behind = behind;
    wy_next.tag.behind = behind;
    wx_next.den = pph_pkg::DEN_W'(1);
    wy_next.den = pph_pkg::DEN_W'(1);
    if (!req.command) begin
      wx_next.word = pph_pkg::NUM_W'(off_x[22] ? -off_x : off_x);
      wy_next.word = pph_pkg::NUM_W'(off_y[22] ? -off_y : off_y);
      wx_next.tag.neg = off_x[22];
      wy_next.tag.neg = off_y[22];
    end else if (!behind) begin
      wx_next.word = pph_pkg::NUM_W'(prod_x[pph_pkg::D_W-1] ? -prod_x : prod_x);
      wy_next.word = pph_pkg::NUM_W'(prod_y[pph_pkg::D_W-1] ? -prod_y : prod_y);
      wx_next.tag.neg = prod_x[pph_pkg::D_W-1];
      wy_next.tag.neg = prod_y[pph_pkg::D_W-1];
      wx_next.den = req.point_z[pph_pkg::DEN_W-1:0];
      wy_next.den = req.point_z[pph_pkg::DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx <= wx_next;
      wy <= wy_next;
    end
  end

endmodule

[rtl/pph_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on pph_pkg; the quotient leaves in the word field of the last stage.
module pph_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  pph_pkg::div_word_t in_word,
  output logic               out_vld,
  output pph_pkg::div_word_t out_word
);

  pph_pkg::div_word_t stg [pph_pkg::NUM_W];
  logic [pph_pkg::NUM_W-1:0] vld;

  for (genvar k = 0; k < pph_pkg::NUM_W; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          stg[k] <= pph_pkg::div_step(in_word);
        end
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en) begin
          vld[k] <= in_vld;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          stg[k] <= pph_pkg::div_step(stg[k-1]);
        end
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign out_vld  = vld[pph_pkg::NUM_W-1];
  assign out_word = stg[pph_pkg::NUM_W-1];

endmodule

[rtl/pph_post.sv]
// Output stages: sign and centre, radius squares and bounds, then the
// result register. Depends on pph_pkg and pph_if.
module pph_post (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  pph_pkg::div_word_t qx,
  input  pph_pkg::div_word_t qy,
  input  pph_pkg::cam_cfg_t  cfg,
  pph_rsp_if.source          rsp
);

  logic                                v1;
  logic                                cmd1;
  logic                                beh1;
  logic signed [pph_pkg::D_W-1:0]      dx1;
  logic signed [pph_pkg::D_W-1:0]      dy1;
  logic signed [pph_pkg::P_W-1:0]      x1;
  logic signed [pph_pkg::P_W-1:0]      y1;
  logic [pph_pkg::SQ_IN_W-1:0]         ax1;
  logic [pph_pkg::SQ_IN_W-1:0]         ay1;

  logic                                v2;
  logic                                cmd2;
  logic                                beh2;
  logic [pph_pkg::SQ_W-1:0]            sqx2;
  logic [pph_pkg::SQ_W-1:0]            sqy2;
  logic                                inb2;
  logic [31:0]                         rx2;
  logic [31:0]                         ry2;

  logic signed [pph_pkg::D_W-1:0]      dx_next;
  logic signed [pph_pkg::D_W-1:0]      dy_next;

  assign dx_next = pph_pkg::apply_sign(qx.word, qx.tag.neg);
  assign dy_next = pph_pkg::apply_sign(qy.word, qy.tag.neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      rsp.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      rsp.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= qx.tag.cmd;
      beh1 <= qx.tag.behind;
      dx1  <= dx_next;
      dy1  <= dy_next;
      x1   <= pph_pkg::add_centre(dx_next, cfg.centre_x);
      y1   <= pph_pkg::add_centre(dy_next, cfg.centre_y);
      ax1  <= pph_pkg::clamp_mag(qx.word);
      ay1  <= pph_pkg::clamp_mag(qy.word);

      cmd2 <= cmd1;
      beh2 <= beh1;
      sqx2 <= ax1 * ax1;
      sqy2 <= ay1 * ay1;
      inb2 <= pph_pkg::in_range(x1, cfg.image_width) &&
              pph_pkg::in_range(y1, cfg.image_height);
      if (beh1) begin
        rx2 <= pph_pkg::NEG_ONE;
        ry2 <= pph_pkg::NEG_ONE;
      end else if (cmd1) begin
        rx2 <= pph_pkg::sat32(x1);
        ry2 <= pph_pkg::sat32(y1);
      end else begin
        rx2 <= dx1[31:0];
        ry2 <= dy1[31:0];
      end

      rsp.res_x         <= $signed(rx2);
      rsp.res_y         <= $signed(ry2);
      rsp.res_z         <= cmd2 ? '0 : cfg.focal_length;
      rsp.behind_viewer <= beh2;
      rsp.pixel_valid   <= !beh2 && inb2 &&
                           pph_pkg::radius_ok(sqx2, sqy2, cfg.circle_radius_sq);
    end
  end

endmodule

[rtl/pinhole_project_unproject.sv]
// Pinhole camera unit: unprojects pixels to directions and projects points to pixels.
// Pipeline from an accepted request beat to its response beat:
// 1 multiply stage, 52 divider stages of one quotient bit each, 3 output stages.
// Throughput: one beat per cycle; the whole pipeline holds while the response waits.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
module pinhole_project_unproject (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [pph_pkg::IDX_W-1:0]  cfg_index,
  input  logic [pph_pkg::CFG_W-1:0]  cfg_data,
  pph_req_if.sink                    req,
  pph_rsp_if.source                  rsp
);

  `include "pinhole_project_unproject_defines.svh"

  pph_pkg::cam_cfg_t  cfg;
  logic               en;
  logic               f_vld;
  pph_pkg::div_word_t f_wx;
  pph_pkg::div_word_t f_wy;
  logic               dx_vld;
  logic               dy_vld;
  pph_pkg::div_word_t qx;
  pph_pkg::div_word_t qy;

  assign en = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre_x         <= pph_pkg::RST_CENTRE_X;
      cfg.centre_y         <= pph_pkg::RST_CENTRE_Y;
      cfg.focal_length     <= pph_pkg::RST_FOCAL_LENGTH;
      cfg.circle_radius_sq <= pph_pkg::RST_RADIUS_SQ;
      cfg.image_width      <= pph_pkg::RST_IMAGE_WIDTH;
      cfg.image_height     <= pph_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pph_pkg::REG_CENTRE_X:     cfg.centre_x         <= cfg_data[pph_pkg::CW-1:0];
        pph_pkg::REG_CENTRE_Y:     cfg.centre_y         <= cfg_data[pph_pkg::CW-1:0];
        pph_pkg::REG_FOCAL_LENGTH: cfg.focal_length     <= cfg_data[pph_pkg::CW-1:0];
        pph_pkg::REG_RADIUS_SQ:    cfg.circle_radius_sq <= cfg_data[pph_pkg::RW-1:0];
        pph_pkg::REG_IMAGE_WIDTH:  cfg.image_width      <= cfg_data[pph_pkg::DW-1:0];
        pph_pkg::REG_IMAGE_HEIGHT: cfg.image_height     <= cfg_data[pph_pkg::DW-1:0];
        default: ;
      endcase
    end
  end

  pph_front u_front (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .req (req),
    .cfg (cfg),
    .vld (f_vld),
    .wx  (f_wx),
    .wy  (f_wy)
  );

  pph_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (f_vld),
    .in_word  (f_wx),
    .out_vld  (dx_vld),
    .out_word (qx)
  );

  pph_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (f_vld),
    .in_word  (f_wy),
    .out_vld  (dy_vld),
    .out_word (qy)
  );

  pph_post u_post (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (dx_vld && dy_vld),
    .qx     (qx),
    .qy     (qy),
    .cfg    (cfg),
    .rsp    (rsp)
  );

  `PPH_ASSERT_IMP(a_stall_holds_input, rsp.valid && !rsp.ready, !req.ready)
  `PPH_ASSERT_IMP(a_behind_not_valid, rsp.valid && rsp.behind_viewer,
                  !rsp.pixel_valid && (rsp.res_z == '0))
  `PPH_ASSERT_IMP(a_behind_marker, rsp.valid && rsp.behind_viewer,
                  rsp.res_x == rsp.res_y)
  `PPH_ASSERT_IMP(a_lanes_aligned, dx_vld || dy_vld, dx_vld && dy_vld)

endmodule

[sim/pinhole_project_unproject_test.sv]
// Self-checking testbench for the pinhole camera unit (project and unproject).
// Depends on rtl/pph_pkg.sv, rtl/pph_if.sv and the top level; predicts every response beat and
// compares it field by field while both channels idle and stall at random.
module pinhole_project_unproject_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {CMD_UNPROJECT = 1'b0, CMD_PROJECT = 1'b1} cmd_e;

  typedef struct {
    cmd_e               cmd;
    logic signed [21:0] pix_x;
    logic signed [21:0] pix_y;
    logic signed [31:0] pt_x;
    logic signed [31:0] pt_y;
    logic signed [31:0] pt_z;
  } cam_req_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [19:0]        z;
    logic               valid;
    logic               behind;
  } cam_rsp_t;

  localparam int DRAIN_CYCLES = 64;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [pph_pkg::IDX_W-1:0] cfg_index;
  logic [pph_pkg::CFG_W-1:0] cfg_data;

  pph_req_if req ();
  pph_rsp_if rsp ();

  pinhole_project_unproject DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req.sink), .rsp(rsp.source)
  );

  pph_pkg::cam_cfg_t cam;
  cam_rsp_t pending_pixels[$];
  int mismatches = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int cfg_writes = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint clamped_square(longint d);
    longint a;
    a = (d < 0) ? -d : d;
    if (a > 64'sd8388608) begin
      a = 64'sd8388608;
    end
    return a * a;
  endfunction

  function automatic bit within_dim(longint v, logic [pph_pkg::DW-1:0] dim);
    longint d;
    d = (dim > pph_pkg::MAX_DIM) ? pph_pkg::MAX_DIM : longint'(dim);
    return v >= 0 && v < (d << pph_pkg::FRAC_BITS);
  endfunction

  function automatic bit pixel_ok(longint x, longint y, longint dx, longint dy);
    longint r2;
    r2 = clamped_square(dx) + clamped_square(dy);
    return r2 <= longint'(cam.circle_radius_sq) && within_dim(x, cam.image_width) &&
           within_dim(y, cam.image_height);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic cam_rsp_t camera_response(cam_req_t r);
    cam_rsp_t o;
    longint cx, cy, f, dx, dy, x, y, pz;
    cx = longint'(cam.centre_x);
    cy = longint'(cam.centre_y);
    f = longint'(cam.focal_length);
    o = '{x: 0, y: 0, z: 0, valid: 0, behind: 0};
    if (r.cmd == CMD_UNPROJECT) begin
      x = longint'(r.pix_x);
      y = longint'(r.pix_y);
      dx = x - cx;
      dy = y - cy;
      o.x = dx[31:0];
      o.y = dy[31:0];
      o.z = cam.focal_length;
      o.valid = pixel_ok(x, y, dx, dy);
    end else begin
      pz = longint'(r.pt_z);
      if (pz <= 0) begin
        // Points at or behind the camera plane map to the fixed pixel (-1,-1).
        o.x = -(32'sd1 <<< pph_pkg::FRAC_BITS);
        o.y = o.x;
        o.behind = 1'b1;
      end else begin
        dx = (longint'(r.pt_x) * f) / pz;
        dy = (longint'(r.pt_y) * f) / pz;
        x = dx + cx;
        y = dy + cy;
        o.x = clip32(x);
        o.y = clip32(y);
        o.valid = pixel_ok(x, y, dx, dy);
      end
    end
    return o;
  endfunction

  // The caller lowers the write enable after the last write.
  task automatic write_reg(logic [pph_pkg::IDX_W-1:0] idx, logic [pph_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_writes++;
    case (idx)
      pph_pkg::REG_CENTRE_X:     cam.centre_x = val[pph_pkg::CW-1:0];
      pph_pkg::REG_CENTRE_Y:     cam.centre_y = val[pph_pkg::CW-1:0];
      pph_pkg::REG_FOCAL_LENGTH: cam.focal_length = val[pph_pkg::CW-1:0];
      pph_pkg::REG_RADIUS_SQ:    cam.circle_radius_sq = val[pph_pkg::RW-1:0];
      pph_pkg::REG_IMAGE_WIDTH:  cam.image_width = val[pph_pkg::DW-1:0];
      pph_pkg::REG_IMAGE_HEIGHT: cam.image_height = val[pph_pkg::DW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_camera(logic [pph_pkg::CW-1:0] cx, logic [pph_pkg::CW-1:0] cy,
                            logic [pph_pkg::CW-1:0] f, logic [pph_pkg::RW-1:0] r2,
                            logic [pph_pkg::DW-1:0] w, logic [pph_pkg::DW-1:0] h);
    req.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(pph_pkg::REG_CENTRE_X, pph_pkg::CFG_W'(cx));
    write_reg(pph_pkg::REG_CENTRE_Y, pph_pkg::CFG_W'(cy));
    write_reg(pph_pkg::REG_FOCAL_LENGTH, pph_pkg::CFG_W'(f));
    write_reg(pph_pkg::REG_RADIUS_SQ, pph_pkg::CFG_W'(r2));
    write_reg(pph_pkg::REG_IMAGE_WIDTH, pph_pkg::CFG_W'(w));
    write_reg(pph_pkg::REG_IMAGE_HEIGHT, pph_pkg::CFG_W'(h));
    cfg_we <= 1'b0;
  endtask

  // Holds the beat until it is taken; valid stays high into the next beat
  // unless an idle gap is drawn.
  task automatic send_beat(cam_req_t r);
    req.valid <= 1'b1;
    req.command <= r.cmd;
    req.pixel_x <= r.pix_x;
    req.pixel_y <= r.pix_y;
    req.point_x <= r.pt_x;
    req.point_y <= r.pt_y;
    req.point_z <= r.pt_z;
    do @(posedge clk); while (!req.ready);
    pending_pixels.push_back(camera_response(r));
    beats_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cam_rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("response beat with nothing expected");
        mismatches++;
      end else begin
        e = pending_pixels.pop_front();
        beats_checked++;
        if (rsp.res_x !== e.x) begin
          $error("res_x expected %0d actual %0d", e.x, rsp.res_x);
          mismatches++;
        end
        if (rsp.res_y !== e.y) begin
          $error("res_y expected %0d actual %0d", e.y, rsp.res_y);
          mismatches++;
        end
        if (rsp.res_z !== e.z) begin
          $error("res_z expected %0d actual %0d", e.z, rsp.res_z);
          mismatches++;
        end
        if (rsp.pixel_valid !== e.valid) begin
          $error("pixel_valid expected %0b actual %0b", e.valid, rsp.pixel_valid);
          mismatches++;
        end
        if (rsp.behind_viewer !== e.behind) begin
          $error("behind_viewer expected %0b actual %0b", e.behind, rsp.behind_viewer);
          mismatches++;
        end
      end
    end
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic cam_req_t unproject_req(int x, int y);
    cam_req_t r;
    r = '{cmd: CMD_UNPROJECT, pix_x: x[21:0], pix_y: y[21:0],
          pt_x: $urandom(), pt_y: $urandom(), pt_z: $urandom()};
    return r;
  endfunction

  function automatic cam_req_t project_req(int x, int y, int z);
    cam_req_t r;
    r = '{cmd: CMD_PROJECT, pix_x: 22'($urandom()), pix_y: 22'($urandom()),
          pt_x: x, pt_y: y, pt_z: z};
    return r;
  endfunction

  // Half land near the image; the rest are raw noise or points at or behind the camera.
  function automatic cam_req_t random_req();
    int z, span;
    case ($urandom_range(5))
      0: return unproject_req($urandom(), $urandom());
      1: return project_req($urandom(), $urandom(), $urandom());
      2: return unproject_req(int'(cam.centre_x) + $signed($urandom_range(0, 400000)) - 200000,
                              int'(cam.centre_y) + $signed($urandom_range(0, 400000)) - 200000);
      3: return project_req($urandom(), $urandom(), -$signed($urandom_range(0, 1000)));
      default: begin
        z = $urandom_range(1, 1 << $urandom_range(1, 24));
        span = z < 1000000 ? z : 1000000;
        return project_req($signed($urandom_range(0, 2 * span)) - span,
                           $signed($urandom_range(0, 2 * span)) - span, z);
      end
    endcase
  endfunction

  task automatic run_random(int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ((4 * k) / n)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (k == n / 2) begin
        req.valid <= 1'b0;
        wait_drained();
      end
      send_beat(random_req());
    end
  endtask

  task automatic test_directed();
    send_beat(unproject_req(2097151, 2097151));
    send_beat(unproject_req(-2097152, -2097152));
    send_beat(unproject_req(0, 0));
    send_beat(unproject_req(81920, 61440));
    send_beat(unproject_req(640 * 256 - 1, 480 * 256 - 1));
    send_beat(unproject_req(640 * 256, 480 * 256));
    send_beat(unproject_req(-1, 100));
    send_beat(project_req(0, 0, 0));
    send_beat(project_req(100, 100, -1));
    send_beat(project_req(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
    send_beat(project_req(32'sh7fffffff, 32'sh80000000, 1));
    send_beat(project_req(32'sh80000000, 32'sh7fffffff, 1));
    send_beat(project_req(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    send_beat(project_req(256, -256, 256));
    send_beat(project_req(0, 0, 256));
    send_beat(project_req(-1000, -1000, 3));
    send_beat(project_req(5, 7, 2));
  endtask

  task automatic test_extreme_settings();
    // Zero-size image, unit focal length and a zero radius limit.
    set_camera(0, 0, 1, 0, 0, 0);
    test_directed();
    run_random(150);
    set_camera(20'hfffff, 20'hfffff, 20'hfffff, {pph_pkg::RW{1'b1}}, 13'h1fff, 13'h1fff);
    test_directed();
    run_random(200);
    set_camera(0, 0, 0, 42'd1 << 40, 13'd1, 13'd1);
    run_random(150);
    set_camera(20'd2048, 20'd2048, 20'd256, 42'd65536 * 100, 4096, 4096);
    run_random(200);
  endtask

  task automatic test_random_settings();
    set_camera($urandom_range(0, 300000), $urandom_range(0, 300000),
               $urandom_range(1, 1048575),
               pph_pkg::RW'({$urandom_range(0, 1023), $urandom()}),
               $urandom_range(1, 4200), $urandom_range(1, 4200));
    run_random(200);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.command = 1'b0;
    req.pixel_x = '0;
    req.pixel_y = '0;
    req.point_x = '0;
    req.point_y = '0;
    req.point_z = '0;
    rsp.ready = 1'b0;
    cam = '{centre_x: pph_pkg::RST_CENTRE_X, centre_y: pph_pkg::RST_CENTRE_Y,
            focal_length: pph_pkg::RST_FOCAL_LENGTH,
            circle_radius_sq: pph_pkg::RST_RADIUS_SQ,
            image_width: pph_pkg::RST_IMAGE_WIDTH,
            image_height: pph_pkg::RST_IMAGE_HEIGHT};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    run_random(200);
    test_extreme_settings();
    test_random_settings();
    test_random_settings();
    req.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d request beats and checked %0d responses across %0d register writes,",
             beats_sent, beats_checked, cfg_writes);
    $display("covering both commands, depth at or below zero, saturation and bounds.");
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
